// ----- design/wavp_pkg.sv -----
// Shared types, codes and header decode tables for the WAV stream parser.
package wavp_pkg;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NOT_RIFF    = 3'd1,
      ST_NOT_WAVE    = 3'd2,
      ST_NO_FMT      = 3'd3,
      ST_FMT_LEN     = 3'd4,
      ST_NO_DATA     = 3'd5,
      ST_SHORT_BLOCK = 3'd6
   } status_type;

   localparam int NumFields = 9;

   localparam logic [3:0] FLD_RIFF_SIZE    = 4'd0;
   localparam logic [3:0] FLD_FMT_LEN      = 4'd1;
   localparam logic [3:0] FLD_FORMAT_TAG   = 4'd2;
   localparam logic [3:0] FLD_CHANNELS     = 4'd3;
   localparam logic [3:0] FLD_RATE_HZ      = 4'd4;
   localparam logic [3:0] FLD_BYTE_RATE    = 4'd5;
   localparam logic [3:0] FLD_BLOCK_ALIGN  = 4'd6;
   localparam logic [3:0] FLD_BITS         = 4'd7;
   localparam logic [3:0] FLD_PAYLOAD      = 4'd8;

   localparam logic [5:0]  FmtSizePos    = 6'd19;
   localparam logic [5:0]  HeaderLastPos = 6'd43;
   localparam logic [31:0] FmtSizePcm    = 32'd16;
   localparam logic [15:0] MinBlockAlign = 16'd4;
   localparam logic [31:0] RiffBias      = 32'd8;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
      logic [1:0] lane;
      logic       last;
   } field_slot_type;

   typedef struct packed {
      logic       check;
      logic [7:0] value;
      status_type code;
   } sig_slot_type;

   // Map a header offset to the little-endian field it feeds.
   function automatic field_slot_type field_slot(input logic [5:0] pos);
      field_slot_type s;
      s.hit  = 1'b1;
      s.idx  = FLD_RIFF_SIZE;
      s.lane = pos[1:0];
      s.last = (pos[1:0] == 2'd3);
      unique case (pos) inside
         [6'd4:6'd7]:   s.idx = FLD_RIFF_SIZE;
         [6'd16:6'd19]: s.idx = FLD_FMT_LEN;
         [6'd20:6'd21]: begin
            s.idx  = FLD_FORMAT_TAG;
            s.last = (pos[1:0] == 2'd1);
         end
         [6'd22:6'd23]: begin
            s.idx  = FLD_CHANNELS;
            s.lane = pos[1:0] - 2'd2;
         end
         [6'd24:6'd27]: s.idx = FLD_RATE_HZ;
         [6'd28:6'd31]: s.idx = FLD_BYTE_RATE;
         [6'd32:6'd33]: begin
            s.idx  = FLD_BLOCK_ALIGN;
            s.last = (pos[1:0] == 2'd1);
         end
         [6'd34:6'd35]: begin
            s.idx  = FLD_BITS;
            s.lane = pos[1:0] - 2'd2;
         end
         [6'd40:6'd43]: s.idx = FLD_PAYLOAD;
         default:       s.hit = 1'b0;
      endcase
      return s;
   endfunction

   // Expected signature byte at a header offset.
   function automatic sig_slot_type sig_slot(input logic [5:0] pos);
      sig_slot_type s;
      s = '{check: 1'b1, value: 8'h00, code: ST_OK};
      unique case (pos)
         6'd0:    begin s.value = 8'h52; s.code = ST_NOT_RIFF; end
         6'd1:    begin s.value = 8'h49; s.code = ST_NOT_RIFF; end
         6'd2:    begin s.value = 8'h46; s.code = ST_NOT_RIFF; end
         6'd3:    begin s.value = 8'h46; s.code = ST_NOT_RIFF; end
         6'd8:    begin s.value = 8'h57; s.code = ST_NOT_WAVE; end
         6'd9:    begin s.value = 8'h41; s.code = ST_NOT_WAVE; end
         6'd10:   begin s.value = 8'h56; s.code = ST_NOT_WAVE; end
         6'd11:   begin s.value = 8'h45; s.code = ST_NOT_WAVE; end
         6'd12:   begin s.value = 8'h66; s.code = ST_NO_FMT;   end
         6'd13:   begin s.value = 8'h6D; s.code = ST_NO_FMT;   end
         6'd14:   begin s.value = 8'h74; s.code = ST_NO_FMT;   end
         6'd36:   begin s.value = 8'h64; s.code = ST_NO_DATA;  end
         6'd37:   begin s.value = 8'h61; s.code = ST_NO_DATA;  end
         6'd38:   begin s.value = 8'h74; s.code = ST_NO_DATA;  end
         6'd39:   begin s.value = 8'h61; s.code = ST_NO_DATA;  end
         default: s.check = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ----- design/wavp_if.sv -----
// Byte input and parse result channel interfaces.
interface wavp_req_if;
   logic       valid;
   logic       ready;
   logic       start_of_file;
   logic [7:0] data_byte;

   modport source (output valid, output start_of_file, output data_byte, input ready);
   modport sink   (input valid, input start_of_file, input data_byte, output ready);
endinterface

interface wavp_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  result_kind;
   logic        [2:0]  status;
   logic        [31:0] riff_length;
   logic        [15:0] format_tag;
   logic        [15:0] num_channels;
   logic        [31:0] rate_hz;
   logic        [31:0] byte_rate;
   logic        [15:0] block_align;
   logic        [15:0] bits_per_sample;
   logic        [31:0] payload_size;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;

   modport source (
      output valid, output result_kind, output status, output riff_length,
      output format_tag, output num_channels, output rate_hz, output byte_rate,
      output block_align, output bits_per_sample, output payload_size,
      output left_sample, output right_sample, input ready
   );
   modport sink (
      input valid, input result_kind, input status, input riff_length,
      input format_tag, input num_channels, input rate_hz, input byte_rate,
      input block_align, input bits_per_sample, input payload_size,
      input left_sample, input right_sample, output ready
   );
endinterface

// ----- design/wav_header_and_sample_parser.sv -----
// Top level: WAV header checker and PCM-16 stereo sample extractor.
//
//   channel | direction | payload                         | handshake
//   req_if  | in        | start_of_file, data_byte        | valid/ready
//   rsp_if  | out       | kind, status, header, L/R pair  | valid/ready
//
// One byte per cycle while the result register is not stalled; a byte passes
// through the input register, then the result register, to its result.
// The input register moves into the parse logic whenever the result register
// is empty or being drained, so a stalled result holds the input register.
// Synchronous reset empties both registers and returns to the header phase.
module wav_header_and_sample_parser
   import wavp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   wavp_req_if.sink     req_if,
   wavp_rsp_if.source   rsp_if
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [31:0]       riff_length;
      logic [15:0]       format_tag;
      logic [15:0]       num_channels;
      logic [31:0]       rate_hz;
      logic [31:0]       byte_rate;
      logic [15:0]       block_align;
      logic [15:0]       bits_per_sample;
      logic [31:0]       payload_size;
      logic [15:0]       left_sample;
      logic [15:0]       right_sample;
   } result_type;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_sof_ff;
   logic [7:0]  in_byte_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [5:0]  hpos_ff, hpos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] cap_ff [NumFields];
   logic [31:0] cap_in [NumFields];
   logic [31:0] rem_ff, rem_in;
   logic [15:0] bpos_ff, bpos_in;
   logic [31:0] first_ff, first_in;

   // result register
   logic        out_valid_ff;
   result_type  out_ff, res_in;

   logic           req_accept, advance, emit, fill_hdr;
   field_slot_type slot;
   sig_slot_type   sig;
   logic [31:0]    lane_word, shift_word;
   logic [4:0]     bsh;

   assign req_accept    = req_if.valid && req_if.ready;
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign in_valid_in   = req_accept || (in_valid_ff && !advance);

   always_comb begin
      phase_in = in_sof_ff ? PH_HEADER : phase_ff;
      hpos_in  = in_sof_ff ? 6'd0 : hpos_ff;
      shift_in = shift_ff;
      cap_in   = cap_ff;
      rem_in   = rem_ff;
      bpos_in  = bpos_ff;
      first_in = first_ff;
      emit     = 1'b0;
      fill_hdr = 1'b0;
      res_in   = '0;
      slot     = field_slot(hpos_in);
      sig      = sig_slot(hpos_in);
      lane_word  = {24'd0, in_byte_ff} << {slot.lane, 3'b000};
      shift_word = (slot.lane == 2'd0) ? lane_word : (shift_ff | lane_word);
      bsh        = {bpos_ff[1:0], 3'b000};

      unique case (phase_in)
         PH_HEADER: begin
            if (sig.check && in_byte_ff != sig.value) begin
               emit          = 1'b1;
               res_in.kind   = KIND_ERROR;
               res_in.status = sig.code;
               phase_in      = PH_STOP;
            end else begin
               if (slot.hit) begin
                  shift_in = shift_word;
                  if (slot.last) cap_in[slot.idx] = shift_word;
               end
               if (hpos_in == FmtSizePos && cap_in[FLD_FMT_LEN] != FmtSizePcm) begin
                  emit          = 1'b1;
                  res_in.kind   = KIND_ERROR;
                  res_in.status = ST_FMT_LEN;
                  phase_in      = PH_STOP;
               end else if (hpos_in == HeaderLastPos) begin
                  emit = 1'b1;
                  if (cap_in[FLD_BLOCK_ALIGN][15:0] < MinBlockAlign) begin
                     res_in.kind   = KIND_ERROR;
                     res_in.status = ST_SHORT_BLOCK;
                     phase_in      = PH_STOP;
                  end else begin
                     fill_hdr    = 1'b1;
                     res_in.kind = KIND_HEADER;
                     rem_in      = cap_in[FLD_PAYLOAD];
                     bpos_in     = 16'd0;
                     first_in    = 32'd0;
                     phase_in    = (cap_in[FLD_PAYLOAD] == 32'd0) ? PH_STOP : PH_DATA;
                  end
               end else begin
                  hpos_in = hpos_in + 6'd1;
               end
            end
         end
         PH_DATA: begin
            rem_in = rem_ff - 32'd1;
            if (bpos_ff < 16'd4) begin
               first_in = (first_ff & ~(32'h0000_00FF << bsh)) |
                          ({24'd0, in_byte_ff} << bsh);
            end
            bpos_in = bpos_ff + 16'd1;
            if (bpos_in == cap_ff[FLD_BLOCK_ALIGN][15:0]) begin
               emit               = 1'b1;
               fill_hdr           = 1'b1;
               res_in.kind        = KIND_SAMPLE;
               res_in.left_sample = first_in[15:0];
               res_in.right_sample = first_in[31:16];
               bpos_in            = 16'd0;
            end
            if (rem_in == 32'd0) phase_in = PH_STOP;
         end
         default: begin
            // stopped: drop bytes until the next start of file
         end
      endcase

      if (fill_hdr) begin
         res_in.riff_length     = cap_in[FLD_RIFF_SIZE] + RiffBias;
         res_in.format_tag      = cap_in[FLD_FORMAT_TAG][15:0];
         res_in.num_channels    = cap_in[FLD_CHANNELS][15:0];
         res_in.rate_hz         = cap_in[FLD_RATE_HZ];
         res_in.byte_rate       = cap_in[FLD_BYTE_RATE];
         res_in.block_align     = cap_in[FLD_BLOCK_ALIGN][15:0];
         res_in.bits_per_sample = cap_in[FLD_BITS][15:0];
         res_in.payload_size    = cap_in[FLD_PAYLOAD];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         hpos_ff      <= 6'd0;
         shift_ff     <= 32'd0;
         rem_ff       <= 32'd0;
         bpos_ff      <= 16'd0;
         first_ff     <= 32'd0;
         for (int i = 0; i < NumFields; i++) cap_ff[i] <= 32'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (req_accept) begin
            in_sof_ff  <= req_if.start_of_file;
            in_byte_ff <= req_if.data_byte;
         end
         if (advance) begin
            phase_ff <= phase_in;
            hpos_ff  <= hpos_in;
            shift_ff <= shift_in;
            cap_ff   <= cap_in;
            rem_ff   <= rem_in;
            bpos_ff  <= bpos_in;
            first_ff <= first_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
            out_ff       <= res_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.result_kind     = out_ff.kind;
   assign rsp_if.status          = out_ff.status;
   assign rsp_if.riff_length     = out_ff.riff_length;
   assign rsp_if.format_tag      = out_ff.format_tag;
   assign rsp_if.num_channels    = out_ff.num_channels;
   assign rsp_if.rate_hz         = out_ff.rate_hz;
   assign rsp_if.byte_rate       = out_ff.byte_rate;
   assign rsp_if.block_align     = out_ff.block_align;
   assign rsp_if.bits_per_sample = out_ff.bits_per_sample;
   assign rsp_if.payload_size    = out_ff.payload_size;
   assign rsp_if.left_sample     = out_ff.left_sample;
   assign rsp_if.right_sample    = out_ff.right_sample;

   a_err_has_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == KIND_ERROR |-> out_ff.status != ST_OK)
      else $error("error transaction without a failure code");

   a_ok_has_no_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind != KIND_ERROR |-> out_ff.status == ST_OK)
      else $error("header or sample transaction with a failure code");

   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result appeared without a parsed byte");

   a_hpos_range: assert property (@(posedge clock) disable iff (reset)
      hpos_ff <= HeaderLastPos)
      else $error("header position past the last header byte");

   a_block_align_min: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> cap_ff[FLD_BLOCK_ALIGN][15:0] >= MinBlockAlign)
      else $error("data phase entered with a short block");

endmodule
